// ===== src/set_pkg.sv =====
// Shared types, fixed-point constants and helpers for the screw exponential transform.
// Used by every module of the block but set_check; depends on nothing.
package set_pkg;

    typedef logic signed [31:0] q_t;

    // Carried item data: axis, angle, flag, the angle-free products and the linear translation
    typedef struct packed {
        q_t [2:0] w;
        q_t       th;
        logic     rot;
        q_t [8:0] w2m;
        q_t [2:0] v;
        q_t [2:0] lt;
    } side_t;

    localparam q_t ONE_Q30  = 32'sh4000_0000;
    localparam q_t GAIN_Q30 = 32'sd652032874;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [32:0] TWO_PI_U = 33'd6746518852;
    localparam int MAX_STEPS = 32;

    // floor((p + 2^29) / 2^30)
    function automatic logic signed [95:0] rnd30(input logic signed [95:0] p);
        logic signed [95:0] t;
        t = p + 96'sd536870912;
        return t >>> 30;
    endfunction

    function automatic q_t sat32(input logic signed [95:0] v);
        q_t r;
        if (v > 96'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -96'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [95:0] v);
        logic signed [47:0] r;
        if (v > 96'sh7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -96'sh8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
        logic signed [34:0] r;
        case (i)
            5'd0:  r = 35'sh3243F6A8;
            5'd1:  r = 35'sh1DAC6705;
            5'd2:  r = 35'sh0FADBAFC;
            5'd3:  r = 35'sh07F56EA6;
            5'd4:  r = 35'sh03FEAB76;
            5'd5:  r = 35'sh01FFD55B;
            5'd6:  r = 35'sh00FFFAAA;
            5'd7:  r = 35'sh007FFF55;
            5'd8:  r = 35'sh003FFFEA;
            5'd9:  r = 35'sh001FFFFD;
            5'd10: r = 35'sh000FFFFF;
            5'd11: r = 35'sh0007FFFF;
            5'd12: r = 35'sh0003FFFF;
            5'd13: r = 35'sh0001FFFF;
            5'd14: r = 35'sh0000FFFF;
            5'd15: r = 35'sh00007FFF;
            5'd16: r = 35'sh00003FFF;
            5'd17: r = 35'sh00001FFF;
            5'd18: r = 35'sh00000FFF;
            5'd19: r = 35'sh000007FF;
            5'd20: r = 35'sh000003FF;
            5'd21: r = 35'sh000001FF;
            5'd22: r = 35'sh000000FF;
            5'd23: r = 35'sh0000007F;
            5'd24: r = 35'sh0000003F;
            5'd25: r = 35'sh0000001F;
            5'd26: r = 35'sh0000000F;
            5'd27: r = 35'sh00000008;
            5'd28: r = 35'sh00000004;
            5'd29: r = 35'sh00000002;
            5'd30: r = 35'sh00000001;
            default: r = 35'sh0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/set_prep.sv =====
// Input stages: squared skew matrix of the axis, v = -w x q and the linear translation.
// Two register stages; depends on set_pkg.
module set_prep (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  set_pkg::q_t    axis_x,
    input  set_pkg::q_t    axis_y,
    input  set_pkg::q_t    axis_z,
    input  set_pkg::q_t    point_x,
    input  set_pkg::q_t    point_y,
    input  set_pkg::q_t    point_z,
    input  set_pkg::q_t    joint_value,
    input  logic           is_rotary,
    output logic           out_valid,
    output set_pkg::side_t out_side
);
    import set_pkg::*;

    logic               vld1_reg;
    q_t                 w_reg [3];
    q_t                 th_reg;
    logic               rot_reg;
    logic signed [63:0] sq_reg [3];
    logic signed [63:0] cr_reg [3];
    logic signed [63:0] wq_reg [6];
    logic signed [63:0] lt_reg [3];
    logic               vld2_reg;
    side_t              side_reg;
    side_t              side_next;

    // Stage 1: raw products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (ce)
            vld1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            w_reg[0]  <= axis_x;
            w_reg[1]  <= axis_y;
            w_reg[2]  <= axis_z;
            th_reg    <= joint_value;
            rot_reg   <= is_rotary;
            sq_reg[0] <= axis_x * axis_x;
            sq_reg[1] <= axis_y * axis_y;
            sq_reg[2] <= axis_z * axis_z;
            cr_reg[0] <= axis_x * axis_y;
            cr_reg[1] <= axis_x * axis_z;
            cr_reg[2] <= axis_y * axis_z;
            wq_reg[0] <= axis_z * point_y;
            wq_reg[1] <= axis_y * point_z;
            wq_reg[2] <= axis_x * point_z;
            wq_reg[3] <= axis_z * point_x;
            wq_reg[4] <= axis_y * point_x;
            wq_reg[5] <= axis_x * point_y;
            lt_reg[0] <= axis_x * joint_value;
            lt_reg[1] <= axis_y * joint_value;
            lt_reg[2] <= axis_z * joint_value;
        end
    end

    // Stage 2: round, combine and saturate
    always_comb
    begin
        logic signed [95:0] s0, s1, s2, c0, c1, c2;
        s0 = rnd30(96'(sq_reg[0]));
        s1 = rnd30(96'(sq_reg[1]));
        s2 = rnd30(96'(sq_reg[2]));
        c0 = rnd30(96'(cr_reg[0]));
        c1 = rnd30(96'(cr_reg[1]));
        c2 = rnd30(96'(cr_reg[2]));
        side_next.w[0]   = w_reg[0];
        side_next.w[1]   = w_reg[1];
        side_next.w[2]   = w_reg[2];
        side_next.th     = th_reg;
        side_next.rot    = rot_reg;
        side_next.w2m[0] = sat32(-(s1 + s2));
        side_next.w2m[4] = sat32(-(s2 + s0));
        side_next.w2m[8] = sat32(-(s0 + s1));
        side_next.w2m[1] = sat32(c0);
        side_next.w2m[3] = sat32(c0);
        side_next.w2m[2] = sat32(c1);
        side_next.w2m[6] = sat32(c1);
        side_next.w2m[5] = sat32(c2);
        side_next.w2m[7] = sat32(c2);
        side_next.v[0] = sat32(rnd30(96'(wq_reg[0])) - rnd30(96'(wq_reg[1])));
        side_next.v[1] = sat32(rnd30(96'(wq_reg[2])) - rnd30(96'(wq_reg[3])));
        side_next.v[2] = sat32(rnd30(96'(wq_reg[4])) - rnd30(96'(wq_reg[5])));
        side_next.lt[0] = sat32(rnd30(96'(lt_reg[0])));
        side_next.lt[1] = sat32(rnd30(96'(lt_reg[1])));
        side_next.lt[2] = sat32(rnd30(96'(lt_reg[2])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (ce)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            side_reg <= side_next;
    end

    assign out_valid = vld2_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/set_reduce.sv =====
// Angle reduction: joint angle modulo 2*pi by restoring subtraction, then folding
// into [-pi/2, pi/2]. Ten register stages; depends on set_pkg.
module set_reduce (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  set_pkg::side_t      in_side,
    output logic                out_valid,
    output set_pkg::side_t      out_side,
    output logic signed [34:0]  out_z,
    output logic                out_flip
);
    import set_pkg::*;

    localparam int SUB_STAGES = 7;
    localparam int DEPTH      = SUB_STAGES + 3;

    logic               vld_reg  [DEPTH];
    side_t              side_reg [DEPTH];
    logic               neg_reg  [SUB_STAGES + 1];
    logic [45:0]        u_reg    [SUB_STAGES + 1];
    logic signed [34:0] ra_reg;
    logic signed [34:0] z_reg;
    logic               flip_reg;
    logic [31:0]        mag;
    logic signed [34:0] ra_next;
    logic signed [34:0] z_next;
    logic               flip_next;

    function automatic logic [45:0] sub_step(input logic [45:0] u, input int k);
        logic [45:0] c;
        c = 46'(TWO_PI_U) << k;
        return (u >= c) ? u - c : u;
    endfunction

    // Advance the valid and item data along all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < DEPTH; s++)
                vld_reg[s] <= vld_reg[s - 1];
        end
    end

    assign mag = in_side.th[31] ? 32'(-in_side.th) : 32'(in_side.th);

    // Fold remainder to [-pi, pi), then to [-pi/2, pi/2]
    always_comb
    begin
        logic [32:0]        rem;
        logic signed [34:0] r0;
        rem = u_reg[SUB_STAGES][32:0];
        if (neg_reg[SUB_STAGES] && (rem != 33'd0))
            r0 = TWO_PI_Q30 - $signed({2'b00, rem});
        else
            r0 = $signed({2'b00, rem});
        ra_next = (r0 >= PI_Q30) ? r0 - TWO_PI_Q30 : r0;
        flip_next = 1'b0;
        z_next = ra_reg;
        if (ra_reg > HALF_PI_Q30)
        begin
            z_next = ra_reg - PI_Q30;
            flip_next = 1'b1;
        end
        else if (ra_reg < -HALF_PI_Q30)
        begin
            z_next = ra_reg + PI_Q30;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < DEPTH; s++)
                side_reg[s] <= side_reg[s - 1];
            u_reg[0]   <= {mag, 14'b0};
            neg_reg[0] <= in_side.th[31];
            for (int s = 1; s <= SUB_STAGES; s++)
            begin
                u_reg[s]   <= sub_step(sub_step(u_reg[s - 1], 15 - 2 * s), 14 - 2 * s);
                neg_reg[s] <= neg_reg[s - 1];
            end
            ra_reg   <= ra_next;
            z_reg    <= z_next;
            flip_reg <= flip_next;
        end
    end

    assign out_valid = vld_reg[DEPTH - 1];
    assign out_side  = side_reg[DEPTH - 1];
    assign out_z     = z_reg;
    assign out_flip  = flip_reg;

endmodule

// ===== src/set_cordic.sv =====
// Rotation-mode CORDIC, one iteration per register stage.
// Depends on set_pkg for the gain and arctangent table.
module set_cordic #(
    parameter int STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  set_pkg::side_t     in_side,
    input  logic signed [34:0] in_z,
    input  logic               in_flip,
    output logic               out_valid,
    output set_pkg::side_t     out_side,
    output logic signed [34:0] out_x,
    output logic signed [34:0] out_y,
    output logic               out_flip
);
    import set_pkg::*;

    localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

    logic               vld_reg  [NS];
    side_t              side_reg [NS];
    logic               flip_reg [NS];
    logic signed [34:0] x_reg    [NS];
    logic signed [34:0] y_reg    [NS];
    logic signed [34:0] z_reg    [NS];

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_step
            logic               vld_src;
            side_t              side_src;
            logic               flip_src;
            logic signed [34:0] x_src, y_src, z_src;
            logic signed [34:0] x_next, y_next, z_next;

            if (i == 0)
            begin : g_first
                assign vld_src  = in_valid;
                assign side_src = in_side;
                assign flip_src = in_flip;
                assign x_src    = 35'(GAIN_Q30);
                assign y_src    = 35'sd0;
                assign z_src    = in_z;
            end
            else
            begin : g_rest
                assign vld_src  = vld_reg[i - 1];
                assign side_src = side_reg[i - 1];
                assign flip_src = flip_reg[i - 1];
                assign x_src    = x_reg[i - 1];
                assign y_src    = y_reg[i - 1];
                assign z_src    = z_reg[i - 1];
            end

            // Rotate toward zero residual angle
            always_comb
            begin
                if (z_src >= 35'sd0)
                begin
                    x_next = x_src - (y_src >>> i);
                    y_next = y_src + (x_src >>> i);
                    z_next = z_src - atan_q30(5'(i));
                end
                else
                begin
                    x_next = x_src + (y_src >>> i);
                    y_next = y_src - (x_src >>> i);
                    z_next = z_src + atan_q30(5'(i));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (ce)
                    vld_reg[i] <= vld_src;
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    side_reg[i] <= side_src;
                    flip_reg[i] <= flip_src;
                    x_reg[i]    <= x_next;
                    y_reg[i]    <= y_next;
                    z_reg[i]    <= z_next;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS - 1];
    assign out_side  = side_reg[NS - 1];
    assign out_x     = x_reg[NS - 1];
    assign out_y     = y_reg[NS - 1];
    assign out_flip  = flip_reg[NS - 1];

endmodule

// ===== src/set_post.sv =====
// Rodrigues assembly: sin/cos clean-up, rotation entries, G matrix and G*v translation.
// Eight register stages, the last one being the output register; depends on set_pkg.
module set_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  set_pkg::side_t     in_side,
    input  logic signed [34:0] in_x,
    input  logic signed [34:0] in_y,
    input  logic               in_flip,
    output logic               out_valid,
    output set_pkg::q_t [8:0]  rot,
    output set_pkg::q_t [2:0]  trans
);
    import set_pkg::*;

    localparam int DEPTH = 8;

    logic               vld_reg  [DEPTH];
    side_t              side_reg [DEPTH - 1];

    q_t                 a_sn_reg, a_cs_reg;
    q_t                 b_sn_reg, b_omc_reg;
    logic signed [47:0] b_tms_reg;
    logic signed [32:0] b_wm_reg  [9];
    logic signed [65:0] c_sw_reg  [9];
    logic signed [65:0] c_ow_reg  [9];
    logic signed [63:0] c_ow2_reg [9];
    logic signed [63:0] c_th_reg  [9];
    logic signed [48:0] c_tl_reg  [9];
    logic signed [51:0] d_sw_reg  [9];
    logic signed [51:0] d_ow_reg  [9];
    logic signed [51:0] d_ow2_reg [9];
    logic signed [51:0] d_tw2_reg [9];
    q_t                 e_r_reg   [9];
    logic signed [47:0] e_g_reg   [9];
    q_t                 f_r_reg   [9];
    logic signed [63:0] f_ph_reg  [9];
    logic signed [48:0] f_pl_reg  [9];
    q_t                 g_r_reg   [9];
    logic signed [51:0] g_m_reg   [9];
    q_t [8:0]           rot_reg;
    q_t [2:0]           trans_reg;

    q_t                 a_sn_next, a_cs_next;
    logic signed [47:0] b_tms_next;

    // Advance valid bits and item data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < DEPTH; s++)
                vld_reg[s] <= vld_reg[s - 1];
        end
    end

    // Stage A: undo the half-turn fold, saturate, force exact values at zero angle
    always_comb
    begin
        logic signed [34:0] sx, sy;
        sx = in_flip ? -in_x : in_x;
        sy = in_flip ? -in_y : in_y;
        a_sn_next = sat32(96'(sy));
        a_cs_next = sat32(96'(sx));
        if (in_side.th == 32'sd0)
        begin
            a_sn_next = 32'sd0;
            a_cs_next = ONE_Q30;
        end
    end

    // Stage B: theta minus sin with 30 fraction bits
    assign b_tms_next = 48'($signed({side_reg[0].th, 14'b0})) - 48'(a_sn_reg);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < DEPTH - 1; s++)
                side_reg[s] <= side_reg[s - 1];

            a_sn_reg <= a_sn_next;
            a_cs_reg <= a_cs_next;

            // Stage B
            b_sn_reg  <= a_sn_reg;
            b_omc_reg <= sat32(96'(ONE_Q30) - 96'(a_cs_reg));
            b_tms_reg <= b_tms_next;
            b_wm_reg[0] <= 33'sd0;
            b_wm_reg[1] <= -33'(side_reg[0].w[2]);
            b_wm_reg[2] <=  33'(side_reg[0].w[1]);
            b_wm_reg[3] <=  33'(side_reg[0].w[2]);
            b_wm_reg[4] <= 33'sd0;
            b_wm_reg[5] <= -33'(side_reg[0].w[0]);
            b_wm_reg[6] <= -33'(side_reg[0].w[1]);
            b_wm_reg[7] <=  33'(side_reg[0].w[0]);
            b_wm_reg[8] <= 33'sd0;

            for (int k = 0; k < 9; k++)
            begin
                // Stage C: products, theta minus sin split into high and low parts
                c_sw_reg[k]  <= b_sn_reg * b_wm_reg[k];
                c_ow_reg[k]  <= b_omc_reg * b_wm_reg[k];
                c_ow2_reg[k] <= b_omc_reg * $signed(side_reg[1].w2m[k]);
                c_th_reg[k]  <= $signed(b_tms_reg[47:16]) * $signed(side_reg[1].w2m[k]);
                c_tl_reg[k]  <= $signed({1'b0, b_tms_reg[15:0]}) *
                                $signed(side_reg[1].w2m[k]);

                // Stage D: round every product
                d_sw_reg[k]  <= 52'(rnd30(96'(c_sw_reg[k])));
                d_ow_reg[k]  <= 52'(rnd30(96'(c_ow_reg[k])));
                d_ow2_reg[k] <= 52'(rnd30(96'(c_ow2_reg[k])));
                d_tw2_reg[k] <= 52'(rnd30((96'(c_th_reg[k]) <<< 16) + 96'(c_tl_reg[k])));

                // Stage E: rotation entry and G entry
                if (k / 3 == k % 3)
                begin
                    e_r_reg[k] <= sat32(96'(ONE_Q30) + 96'(d_sw_reg[k]) + 96'(d_ow2_reg[k]));
                    e_g_reg[k] <= sat48(96'(d_ow_reg[k]) + 96'(d_tw2_reg[k]) +
                                        96'($signed({side_reg[3].th, 14'b0})));
                end
                else
                begin
                    e_r_reg[k] <= sat32(96'(d_sw_reg[k]) + 96'(d_ow2_reg[k]));
                    e_g_reg[k] <= sat48(96'(d_ow_reg[k]) + 96'(d_tw2_reg[k]));
                end

                // Stage F: G times v, G split into high and low parts
                f_r_reg[k]  <= e_r_reg[k];
                f_ph_reg[k] <= $signed(e_g_reg[k][47:16]) * $signed(side_reg[4].v[k % 3]);
                f_pl_reg[k] <= $signed({1'b0, e_g_reg[k][15:0]}) *
                               $signed(side_reg[4].v[k % 3]);

                // Stage G: round each term
                g_r_reg[k] <= f_r_reg[k];
                g_m_reg[k] <= 52'(rnd30((96'(f_ph_reg[k]) <<< 16) + 96'(f_pl_reg[k])));
            end

            // Stage H: sum rows, select linear or rotary result
            for (int r = 0; r < 3; r++)
            begin
                if (side_reg[6].rot)
                    trans_reg[r] <= sat32(96'(g_m_reg[3 * r]) + 96'(g_m_reg[3 * r + 1]) +
                                          96'(g_m_reg[3 * r + 2]));
                else
                    trans_reg[r] <= side_reg[6].lt[r];
            end
            for (int k = 0; k < 9; k++)
            begin
                if (side_reg[6].rot)
                    rot_reg[k] <= g_r_reg[k];
                else if (k / 3 == k % 3)
                    rot_reg[k] <= ONE_Q30;
                else
                    rot_reg[k] <= 32'sd0;
            end
        end
    end

    assign out_valid = vld_reg[DEPTH - 1];
    assign rot       = rot_reg;
    assign trans     = trans_reg;

endmodule

// ===== src/screw_exponential_transform.sv =====
// Top level of the screw exponential transform: stream ports, pipeline enable and
// the chain prep -> reduce -> cordic -> post. Depends on set_pkg and all set_* modules.
//
//   channel | direction | content
//   s_*     | in        | tdata: axis_x,y,z, point_x,y,z, joint_value; tuser: is_rotary
//   m_*     | out       | tdata: rot_00..rot_22, trans_x,y,z
//
// One request per cycle enters while the output is not stalled, since each CORDIC
// iteration has its own pipeline stage (steps capped at 32).
// The whole pipeline advances when the output register is empty or taken, so a
// stall freezes every stage and nothing is dropped or repeated.
// Reset clears all valid bits; item data registers are not reset.
module screw_exponential_transform #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // axis_x, axis_y, axis_z, point_x, point_y, point_z, joint_value (32 bits each)
    input  logic [223:0] s_tdata,
    // is_rotary
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    // trans_x, trans_y, trans_z (32 bits each)
    output logic [383:0] m_tdata
);
    import set_pkg::*;

    logic               ce;
    logic               prep_valid, red_valid, cor_valid;
    side_t              prep_side, red_side, cor_side;
    logic signed [34:0] red_z, cor_x, cor_y;
    logic               red_flip, cor_flip;
    q_t [8:0]           rot;
    q_t [2:0]           trans;

    // Advance when the output register is free
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    set_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .ce          (ce),
        .in_valid    (s_tvalid),
        .axis_x      ($signed(s_tdata[31:0])),
        .axis_y      ($signed(s_tdata[63:32])),
        .axis_z      ($signed(s_tdata[95:64])),
        .point_x     ($signed(s_tdata[127:96])),
        .point_y     ($signed(s_tdata[159:128])),
        .point_z     ($signed(s_tdata[191:160])),
        .joint_value ($signed(s_tdata[223:192])),
        .is_rotary   (s_tuser[0]),
        .out_valid   (prep_valid),
        .out_side    (prep_side)
    );

    set_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (prep_valid),
        .in_side   (prep_side),
        .out_valid (red_valid),
        .out_side  (red_side),
        .out_z     (red_z),
        .out_flip  (red_flip)
    );

    set_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (red_valid),
        .in_side   (red_side),
        .in_z      (red_z),
        .in_flip   (red_flip),
        .out_valid (cor_valid),
        .out_side  (cor_side),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_flip  (cor_flip)
    );

    set_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (cor_valid),
        .in_side   (cor_side),
        .in_x      (cor_x),
        .in_y      (cor_y),
        .in_flip   (cor_flip),
        .out_valid (m_tvalid),
        .rot       (rot),
        .trans     (trans)
    );

    assign m_tdata = {trans[2], trans[1], trans[0],
                      rot[8], rot[7], rot[6], rot[5], rot[4],
                      rot[3], rot[2], rot[1], rot[0]};

endmodule

// ===== src/set_check.sv =====
// Port-level checks for the screw exponential transform, bound to the top level.
// Depends only on the top level's ports.
module set_check (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [383:0] m_tdata
);

    // Input side stalls exactly when a result waits untaken
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // A waiting result holds its value
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result right after reset
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind screw_exponential_transform set_check u_set_check (.*);

// ===== tb/tb_screw_exponential_transform.sv =====
// Self-checking testbench for the screw exponential transform: streams joint screws in,
// predicts each 3x4 transform in fixed point and compares it with the block's output.
// Depends on set_pkg and screw_exponential_transform.
module tb_screw_exponential_transform;
    import set_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef q_t [11:0] xform_t;

    localparam int     STEPS     = 24;
    localparam longint TWO_PI    = 64'sd6746518852;
    localparam longint PI_V      = 64'sd3373259426;
    localparam longint HALF_PI   = 64'sd1686629713;
    localparam longint ONE       = 64'sd1073741824;
    localparam int     LIMIT     = 400000;
    localparam longint ARCTAN [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000};

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [383:0] m_tdata;

    xform_t transforms_due[$];
    int     error_count;
    int     cycle_count;
    int     send_gap_pct;
    int     recv_stall_pct;
    int     hold_left;
    string  field_names [12] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                                 "rot_20", "rot_21", "rot_22", "trans_x", "trans_y", "trans_z"};

    screw_exponential_transform dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // floor((a*b + 2^29) / 2^30)
    function automatic wide_t mul_round(input wide_t a, input wide_t b);
        return (a * b + (wide_t'(1) <<< 29)) >>> 30;
    endfunction

    function automatic wide_t clamp(input wide_t v, input int bits);
        wide_t hi;
        hi = (wide_t'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // CORDIC sine and cosine of a Q16.16 angle after reduction to [-pi/2, pi/2]
    task automatic sine_cosine(input longint angle, output wide_t sn, output wide_t cs);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r = (angle * 16384) % TWO_PI;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (r < 0)
            r += TWO_PI;
        if (r >= PI_V)
            r -= TWO_PI;
        if (r > HALF_PI)
        begin
            r -= PI_V;
            flip = 1'b1;
        end
        else if (r < -HALF_PI)
        begin
            r += PI_V;
            flip = 1'b1;
        end
        z = r;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ARCTAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ARCTAN[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = clamp(y, 32);
        cs = clamp(x, 32);
    endtask

    // Expected transform for one screw: w = axis, q = point, th = joint value
    task automatic predict_transform(input q_t [2:0] w, input q_t [2:0] q, input q_t th,
                                     input bit rotary, output xform_t res);
        wide_t sn, cs, omc, tms, th30, acc, g, rv;
        wide_t skew [3][3];
        wide_t sq [3][3];
        wide_t v [3];
        int    a, b;
        th30 = wide_t'(th) * 16384;
        for (int i = 0; i < 9; i++)
            res[i] = (i % 4 == 0) ? q_t'(ONE) : '0;
        if (!rotary)
        begin
            for (int i = 0; i < 3; i++)
                res[9 + i] = q_t'(clamp(mul_round(w[i], th), 32));
            return;
        end
        sn = 0;
        cs = ONE;
        if (th != 0)
            sine_cosine(th, sn, cs);
        omc = clamp(ONE - cs, 32);
        tms = th30 - sn;
        skew[0][0] = 0;     skew[0][1] = -wide_t'(w[2]); skew[0][2] = w[1];
        skew[1][0] = w[2];  skew[1][1] = 0;              skew[1][2] = -wide_t'(w[0]);
        skew[2][0] = -wide_t'(w[1]); skew[2][1] = w[0];  skew[2][2] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                a = (i + 1) % 3;
                b = (i + 2) % 3;
                if (i == j)
                    sq[i][j] = clamp(-(mul_round(w[a], w[a]) + mul_round(w[b], w[b])), 32);
                else
                    sq[i][j] = clamp(mul_round(w[i], w[j]), 32);
            end
        v[0] = clamp(mul_round(w[2], q[1]) - mul_round(w[1], q[2]), 32);
        v[1] = clamp(mul_round(w[0], q[2]) - mul_round(w[2], q[0]), 32);
        v[2] = clamp(mul_round(w[1], q[0]) - mul_round(w[0], q[1]), 32);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                g = mul_round(omc, skew[i][j]) + mul_round(tms, sq[i][j]);
                if (i == j)
                    g += th30;
                g = clamp(g, 48);
                rv = ((i == j) ? ONE : 0) + mul_round(sn, skew[i][j])
                     + mul_round(omc, sq[i][j]);
                res[i * 3 + j] = q_t'(clamp(rv, 32));
                acc += mul_round(g, v[j]);
            end
            res[9 + i] = q_t'(clamp(acc, 32));
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    // Predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        xform_t exp_x;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_transform({s_tdata[95:64], s_tdata[63:32], s_tdata[31:0]},
                              {s_tdata[191:160], s_tdata[159:128], s_tdata[127:96]},
                              s_tdata[223:192], s_tuser[0], exp_x);
            transforms_due.push_back(exp_x);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (transforms_due.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                exp_x = transforms_due.pop_front();
                for (int k = 0; k < 12; k++)
                    if (m_tdata[32 * k +: 32] !== exp_x[k])
                        report_mismatch($sformatf("%s got %h expected %h", field_names[k],
                                                  m_tdata[32 * k +: 32], exp_x[k]));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_screw(input q_t [2:0] w, input q_t [2:0] q, input q_t th,
                              input bit rotary);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {th, q[2], q[1], q[0], w[2], w[1], w[0]};
        s_tuser  <= rotary;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic q_t pick_axis();
        case ($urandom_range(5))
            0: return q_t'(ONE);
            1: return -q_t'(ONE);
            2: return '0;
            3: return q_t'($urandom);
            default: return q_t'($signed($urandom_range(2 * ONE)) - ONE);
        endcase
    endfunction

    function automatic q_t pick_point();
        if ($urandom_range(9) == 0)
            return q_t'($urandom);
        return q_t'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
    endfunction

    function automatic q_t pick_joint();
        case ($urandom_range(7))
            0: return q_t'($urandom);
            1: return '0;
            2: return q_t'($signed($urandom_range(32'h0064_0000)) - 32'sh0032_0000);
            default: return q_t'($signed($urandom_range(32'h000E_0000)) - 32'sh0007_0000);
        endcase
    endfunction

    task automatic drop_valid();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        wait (transforms_due.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    // Unit axes, zero angle, linear joints, angle wrap and field extremes
    task automatic test_directed();
        q_t [2:0] ux, uy, uz, zero3, pmax, pmin;
        ux = {32'sd0, 32'sd0, q_t'(ONE)};
        uy = {32'sd0, q_t'(ONE), 32'sd0};
        uz = {q_t'(ONE), 32'sd0, 32'sd0};
        zero3 = '0;
        pmax = {3{32'sh7FFF_FFFF}};
        pmin = {3{32'sh8000_0000}};
        send_screw(uz, {32'sd0, 32'sh0001_0000, 32'sh0002_0000}, 32'sd0, 1'b1);
        send_screw(uz, {32'sd0, 32'sh0001_0000, 32'sh0002_0000}, 32'sh0001_0000, 1'b1);
        send_screw(ux, {32'sh0003_0000, 32'sd0, 32'sd0}, 32'sh0003_243F, 1'b1);
        send_screw(uy, {32'sh0003_0000, 32'sd0, 32'sh0005_0000}, -32'sh0003_243F, 1'b1);
        send_screw(uz, {32'sd0, 32'sh0010_0000, 32'sd0}, 32'sh0001_921F, 1'b1);
        send_screw(uz, {32'sd0, 32'sh0010_0000, 32'sd0}, -32'sh0001_921F, 1'b1);
        send_screw(uz, {32'sd0, 32'sh0001_0000, 32'sh0001_0000}, 32'sh7FFF_FFFF, 1'b1);
        send_screw(uy, {32'sd0, 32'sh0001_0000, 32'sh0001_0000}, 32'sh8000_0000, 1'b1);
        send_screw(pmax, pmax, 32'sh7FFF_FFFF, 1'b1);
        send_screw(pmin, pmin, 32'sh8000_0000, 1'b1);
        send_screw(pmax, pmin, 32'sh0001_0000, 1'b1);
        send_screw({32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000},
                   {32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000}, 32'sh0000_8000, 1'b1);
        send_screw(ux, pmax, 32'sh0064_0000, 1'b0);
        send_screw(uy, pmin, -32'sh0064_0000, 1'b0);
        send_screw(uz, zero3, 32'sd0, 1'b0);
        send_screw(pmax, zero3, 32'sh7FFF_FFFF, 1'b0);
        send_screw(pmin, zero3, 32'sh8000_0000, 1'b0);
        send_screw(pmin, pmax, 32'sh7FFF_FFFF, 1'b0);
        send_screw(zero3, zero3, 32'sh0001_0000, 1'b1);
        drop_valid();
        drain();
    endtask

    task automatic test_random(input int count, input int gap_pct, input int stall_pct);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
            send_screw({pick_axis(), pick_axis(), pick_axis()},
                       {pick_point(), pick_point(), pick_point()},
                       pick_joint(), $urandom_range(3) != 0);
        drop_valid();
        drain();
    endtask

    // Long receiver hold-off while requests keep coming, so the pipeline fills and stalls
    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        for (int n = 0; n < 120; n++)
            send_screw({pick_axis(), pick_axis(), pick_axis()},
                       {pick_point(), pick_point(), pick_point()},
                       pick_joint(), $urandom_range(3) != 0);
        drop_valid();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_left = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(300, 12, 58);
        test_random(300, 58, 12);
        test_random(300, 0, 0);
        test_backpressure();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
src/set_pkg.sv
src/set_prep.sv
src/set_reduce.sv
src/set_cordic.sv
src/set_post.sv
src/screw_exponential_transform.sv
src/set_check.sv
tb/tb_screw_exponential_transform.sv
